// File: rtl/lgc_pkg.sv
`default_nettype none
package lgc_pkg;
  localparam int unsigned SLOTS = 96;
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [23:0] BUDGET_RESET = 24'(192 * 1024);

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_REJECT = 3'd2;
  localparam logic [2:0] ST_RFAIL = 3'd3;
  localparam logic [2:0] ST_SFAIL = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_FONT = 1'b1;

  typedef struct packed {
    logic [20:0] code;
    logic [7:0]  size;
    logic [31:0] stamp;
    logic [15:0] nbytes;
  } entry_t;
endpackage
`default_nettype wire

// File: rtl/lru_glyph_cache_byte_budget.sv
`default_nettype none
// Tag and LRU policy engine of a 96-slot fully associative glyph cache keyed
// by (code point, pixel size) with a byte budget. Entry tags, stamps and byte
// counts live in one synchronous RAM; valid bits are flip-flops. One beat is
// handled at a time. A clear or a rejected request goes straight from idle to
// the result state. Every other lookup scans the slots through the RAM read
// port, stopping early on a hit, before the result handshake. A miss adds one
// scan for the oldest slot when the cache is full, plus one scan per entry
// evicted for the budget, and one more scan when the budget runs out of
// victims. The single RAM read port makes every scan visit the slots one
// address at a time. The result is held in an output register; the next
// beat is taken once the result has been delivered.
module lru_glyph_cache_byte_budget import lgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [20:0] in_key_code,
  input  wire logic [7:0]  in_glyph_size,
  input  wire logic [15:0] in_glyph_bytes,
  input  wire logic        in_render_ok,
  input  wire logic        in_store_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [6:0]       out_slot,
  output logic [6:0]       out_evicted_count,
  output logic [31:0]      out_hit_total,
  output logic [31:0]      out_miss_total,
  output logic [6:0]       out_glyph_count,
  output logic [24:0]      out_byte_total
);
  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_FILL, S_VICTIM, S_BUDGET, S_DROP, S_WRITE, S_OUT
  } state_t;

  state_t          state_r;
  logic [23:0]     budget_r;
  logic            font_r;
  logic [SLOTS-1:0] valid_r;
  logic [31:0]     stamp_r, hits_r, misses_r;
  logic [CW-1:0]   vcount_r;
  logic [24:0]     bytes_r;

  // request latch
  logic [20:0]     code_r;
  logic [7:0]      size_r;
  logic [15:0]     nb_r;
  logic            rok_r, sok_r;

  // scan
  logic [CW-1:0]   scan_r;   // address issued
  logic            rv_r;     // read data valid
  logic [SW-1:0]   ridx_r;   // address of read data
  logic            best_ok_r;
  logic [SW-1:0]   best_r;
  logic [31:0]     best_stamp_r;
  logic [15:0]     best_bytes_r;
  logic [SW-1:0]   target_r;
  logic [6:0]      evict_r;

  logic            we;
  logic [SW-1:0]   waddr;
  entry_t          wdata, rdata;

  lgc_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(scan_r[SW-1:0]), .rdata(rdata)
  );

  // first free slot, priority search over valid flops
  logic            free_ok;
  logic [SW-1:0]   free_idx;
  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  logic        scan_done;
  logic [25:0] need;
  assign scan_done = (scan_r == CW'(SLOTS));
  assign need = {1'b0, bytes_r} + {10'd0, nb_r};
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      budget_r <= BUDGET_RESET;
      font_r <= 1'b0;
      valid_r <= '0;
      stamp_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      vcount_r <= '0;
      bytes_r <= '0;
      out_valid <= 1'b0;
      rv_r <= 1'b0;
      scan_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BUDGET: budget_r <= cfg_data;
          CFG_FONT:   font_r <= cfg_data[0];
          default: ;
        endcase
      end
      rv_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            code_r <= in_key_code;
            size_r <= in_glyph_size;
            nb_r <= in_glyph_bytes;
            rok_r <= in_render_ok;
            sok_r <= in_store_ok;
            out_slot <= '0;
            out_evicted_count <= '0;
            evict_r <= '0;
            if (in_command) begin
              valid_r <= '0;
              vcount_r <= '0;
              bytes_r <= '0;
              hits_r <= '0;
              misses_r <= '0;
              stamp_r <= '0;
              out_status <= ST_CLEAR;
              state_r <= S_OUT;
            end else if (!font_r || in_glyph_size == 8'd0) begin
              out_status <= ST_REJECT;
              state_r <= S_OUT;
            end else begin
              scan_r <= '0;
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          // issue addresses, compare returning tags
          if (!scan_done) begin
            scan_r <= scan_r + 1'b1;
            rv_r <= 1'b1;
            ridx_r <= scan_r[SW-1:0];
          end
          if (rv_r && valid_r[ridx_r] && rdata.code == code_r && rdata.size == size_r) begin
            stamp_r <= stamp_r + 1'b1;
            hits_r <= hits_r + 1'b1;
            we <= 1'b1;
            waddr <= ridx_r;
            wdata <= '{code: rdata.code, size: rdata.size,
                       stamp: stamp_r + 1'b1, nbytes: rdata.nbytes};
            out_slot <= 7'(ridx_r);
            out_status <= ST_HIT;
            rv_r <= 1'b0;
            state_r <= S_OUT;
          end else if (scan_done && !rv_r) begin
            if (!rok_r) begin
              out_status <= ST_RFAIL;
              state_r <= S_OUT;
            end else if (free_ok) begin
              target_r <= free_idx;
              state_r <= S_WRITE;
            end else begin
              scan_r <= '0;
              best_ok_r <= 1'b0;
              state_r <= S_FILL;
            end
          end
        end
        S_FILL, S_BUDGET: begin
          // oldest valid slot, skipping target during the budget loop
          if (!scan_done) begin
            scan_r <= scan_r + 1'b1;
            rv_r <= 1'b1;
            ridx_r <= scan_r[SW-1:0];
          end
          if (rv_r && valid_r[ridx_r] && !(state_r == S_BUDGET && ridx_r == target_r) &&
              (!best_ok_r || rdata.stamp < best_stamp_r)) begin
            best_ok_r <= 1'b1;
            best_r <= ridx_r;
            best_stamp_r <= rdata.stamp;
            best_bytes_r <= rdata.nbytes;
          end
          if (scan_done && !rv_r) begin
            state_r <= (state_r == S_FILL) ? S_VICTIM : S_DROP;
          end
        end
        S_VICTIM: begin
          // full cache: the oldest slot is replaced by the new entry
          valid_r[best_r] <= 1'b0;
          if (bytes_r >= 25'(best_bytes_r)) bytes_r <= bytes_r - 25'(best_bytes_r);
          vcount_r <= vcount_r - 1'b1;
          evict_r <= evict_r + 1'b1;
          target_r <= best_r;
          state_r <= S_WRITE;
        end
        S_DROP: begin
          if (best_ok_r) begin
            // budget eviction done, re-check budget
            valid_r[best_r] <= 1'b0;
            if (bytes_r >= 25'(best_bytes_r)) bytes_r <= bytes_r - 25'(best_bytes_r);
            vcount_r <= vcount_r - 1'b1;
            evict_r <= evict_r + 1'b1;
            state_r <= S_WRITE;
          end else begin
            // no victim left: finish budget loop
            state_r <= S_OUT;
            if (!sok_r) begin
              valid_r[target_r] <= 1'b0;
              vcount_r <= vcount_r - 1'b1;
              out_status <= ST_SFAIL;
            end else begin
              bytes_r <= 25'(need);
              misses_r <= misses_r + 1'b1;
              out_slot <= 7'(target_r);
              out_status <= ST_MISS;
            end
            out_evicted_count <= evict_r;
          end
        end
        S_WRITE: begin
          // install entry when target not yet valid, then check budget
          if (!valid_r[target_r]) begin
            valid_r[target_r] <= 1'b1;
            vcount_r <= vcount_r + 1'b1;
            stamp_r <= stamp_r + 1'b1;
            we <= 1'b1;
            waddr <= target_r;
            wdata <= '{code: code_r, size: size_r, stamp: stamp_r + 1'b1, nbytes: nb_r};
          end else if (nb_r == 16'd0) begin
            misses_r <= misses_r + 1'b1;
            out_slot <= 7'(target_r);
            out_status <= ST_MISS;
            out_evicted_count <= evict_r;
            state_r <= S_OUT;
          end else if (need > {2'b0, budget_r}) begin
            scan_r <= '0;
            best_ok_r <= 1'b0;
            state_r <= S_BUDGET;
          end else if (!sok_r) begin
            valid_r[target_r] <= 1'b0;
            vcount_r <= vcount_r - 1'b1;
            out_status <= ST_SFAIL;
            out_evicted_count <= evict_r;
            state_r <= S_OUT;
          end else begin
            bytes_r <= 25'(need);
            misses_r <= misses_r + 1'b1;
            out_slot <= 7'(target_r);
            out_status <= ST_MISS;
            out_evicted_count <= evict_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_hit_total = hits_r;
  assign out_miss_total = misses_r;
  assign out_glyph_count = 7'(vcount_r);
  assign out_byte_total = bytes_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r == CW'($countones(valid_r)))
    else $error("valid count differs from valid bits");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("pending result changed");
endmodule
`default_nettype wire

// File: rtl/lgc_ram.sv
`default_nettype none
module lgc_ram import lgc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [SW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [SW-1:0] raddr,
  output entry_t             rdata
);
  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sim/lru_glyph_cache_byte_budget_tb.sv
`timescale 1ns / 100ps

module lru_glyph_cache_byte_budget_tb;
  import lgc_pkg::*;

  // one request beat as the sender offers it
  typedef struct {
    logic        command;
    logic [20:0] key_code;
    logic [7:0]  glyph_size;
    logic [15:0] glyph_bytes;
    logic        render_ok;
    logic        store_ok;
  } glyph_req_t;

  // one result beat as the block reports it
  typedef struct {
    logic [2:0]  status;
    logic [6:0]  slot;
    logic [6:0]  evicted;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [6:0]  count;
    logic [24:0] bytes;
  } glyph_rsp_t;

  // directed stimulus row: either a register write or a beat, with an
  // optional hand-written expectation
  typedef struct {
    bit          is_cfg;
    logic        reg_index;
    logic [23:0] reg_value;
    glyph_req_t  req;
    bit          typed;
    glyph_rsp_t  rsp;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_BUDGET;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [20:0] in_key_code = '0;
  logic [7:0]  in_glyph_size = '0;
  logic [15:0] in_glyph_bytes = '0;
  logic        in_render_ok = 1'b0;
  logic        in_store_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [6:0]  out_slot;
  logic [6:0]  out_evicted_count;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;
  logic [6:0]  out_glyph_count;
  logic [24:0] out_byte_total;

  lru_glyph_cache_byte_budget u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_key_code(in_key_code),
    .in_glyph_size(in_glyph_size), .in_glyph_bytes(in_glyph_bytes),
    .in_render_ok(in_render_ok), .in_store_ok(in_store_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot(out_slot),
    .out_evicted_count(out_evicted_count),
    .out_hit_total(out_hit_total), .out_miss_total(out_miss_total),
    .out_glyph_count(out_glyph_count), .out_byte_total(out_byte_total)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // cache mirror: own copy of tags, stamps, counters and registers
  // ---------------------------------------------------------------------
  logic        line_valid [SLOTS];
  logic [20:0] line_code  [SLOTS];
  logic [7:0]  line_size  [SLOTS];
  logic [31:0] line_stamp [SLOTS];
  logic [15:0] line_bytes [SLOTS];
  logic [31:0] stamp_now;
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  int unsigned lines_used;
  int unsigned bytes_held;
  int unsigned budget_reg;
  logic        font_reg;

  glyph_rsp_t  pending_rsp [$];
  int          fail_count = 0;
  int          status_seen [6];
  int          beats_sent = 0;
  bit          hold_long = 1'b0;   // receiver: one long hold-off on request
  bit          no_gaps = 1'b0;     // both sides: run back to back

  task automatic mirror_reset();
    for (int i = 0; i < SLOTS; i++) line_valid[i] = 1'b0;
    stamp_now = '0;
    hit_cnt = '0;
    miss_cnt = '0;
    lines_used = 0;
    bytes_held = 0;
    budget_reg = 32'(BUDGET_RESET);
    font_reg = 1'b0;
  endtask

  // oldest valid line other than skip, SLOTS if none; ties go to the lowest
  function automatic int oldest_line(int skip);
    int pick;
    pick = SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (!line_valid[i] || i == skip) continue;
      if (pick == SLOTS || line_stamp[i] < line_stamp[pick]) pick = i;
    end
    return pick;
  endfunction

  task automatic drop_line(int i);
    if (line_valid[i]) begin
      line_valid[i] = 1'b0;
      if (bytes_held >= line_bytes[i]) bytes_held -= line_bytes[i];
      if (lines_used != 0) lines_used--;
    end
  endtask

  task automatic cache_lookup(input glyph_req_t r, output glyph_rsp_t o);
    int found, target, victim, ev;
    bit kept;
    found = SLOTS;
    target = SLOTS;
    ev = 0;
    kept = 1'b1;
    o.slot = '0;
    if (r.command) begin
      for (int i = 0; i < SLOTS; i++) line_valid[i] = 1'b0;
      lines_used = 0;
      bytes_held = 0;
      hit_cnt = '0;
      miss_cnt = '0;
      stamp_now = '0;
      o.status = ST_CLEAR;
    end else if (!font_reg || r.glyph_size == 0) begin
      o.status = ST_REJECT;
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (found == SLOTS && line_valid[i] && line_code[i] == r.key_code &&
            line_size[i] == r.glyph_size) found = i;
      if (found < SLOTS) begin
        stamp_now++;
        line_stamp[found] = stamp_now;
        hit_cnt++;
        o.slot = found[6:0];
        o.status = ST_HIT;
      end else if (!r.render_ok) begin
        o.status = ST_RFAIL;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (target == SLOTS && !line_valid[i]) target = i;
        // full cache: the least recently used line makes room
        if (target == SLOTS) begin
          target = oldest_line(SLOTS);
          drop_line(target);
          ev++;
        end
        line_valid[target] = 1'b1;
        line_code[target] = r.key_code;
        line_size[target] = r.glyph_size;
        stamp_now++;
        line_stamp[target] = stamp_now;
        line_bytes[target] = r.glyph_bytes;
        lines_used++;
        // zero-byte glyphs skip the budget and ignore store_ok
        if (r.glyph_bytes != 0) begin
          victim = 0;
          while (bytes_held + r.glyph_bytes > budget_reg && victim < SLOTS) begin
            victim = oldest_line(target);
            if (victim < SLOTS) begin
              drop_line(victim);
              ev++;
            end
          end
          // failed store: the new line goes, its bytes were never counted
          if (!r.store_ok) begin
            kept = 1'b0;
            line_valid[target] = 1'b0;
            if (lines_used != 0) lines_used--;
          end else begin
            bytes_held = (bytes_held + r.glyph_bytes) & 32'h1FF_FFFF;
          end
        end
        if (kept) begin
          miss_cnt++;
          o.slot = target[6:0];
          o.status = ST_MISS;
        end else begin
          o.status = ST_SFAIL;
        end
      end
    end
    o.evicted = ev[6:0];
    o.hits = hit_cnt;
    o.misses = miss_cnt;
    o.count = lines_used[6:0];
    o.bytes = bytes_held[24:0];
  endtask

  // ---------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    fail_count++;
  endtask

  initial begin
    int wait_n;
    glyph_rsp_t want;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        wait_n = 600;        // long hold-off so the block backs up
        hold_long = 1'b0;
      end else begin
        wait_n = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      if (pending_rsp.size() == 0) begin
        $display("tb: unexpected result beat at %0t, status %0d", $time, out_status);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_status <= ST_CLEAR) status_seen[out_status]++;
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
        if (out_evicted_count !== want.evicted)
          report_mismatch("evicted_count", out_evicted_count, want.evicted);
        if (out_hit_total !== want.hits)
          report_mismatch("hit_total", out_hit_total, want.hits);
        if (out_miss_total !== want.misses)
          report_mismatch("miss_total", out_miss_total, want.misses);
        if (out_glyph_count !== want.count)
          report_mismatch("glyph_count", out_glyph_count, want.count);
        if (out_byte_total !== want.bytes)
          report_mismatch("byte_total", out_byte_total, want.bytes);
      end
    end
  end

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------
  // stop offering, then wait until every logged result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // register writes only happen with the block idle
  task automatic write_reg(logic idx, logic [23:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BUDGET) budget_reg = 32'(value);
    else font_reg = value[0];
  endtask

  // offer one beat, hold it until taken, then log what it must produce
  task automatic send_beat(glyph_req_t r, bit typed, glyph_rsp_t typed_rsp);
    int gap;
    glyph_rsp_t calc;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= r.command;
    in_key_code <= r.key_code;
    in_glyph_size <= r.glyph_size;
    in_glyph_bytes <= r.glyph_bytes;
    in_render_ok <= r.render_ok;
    in_store_ok <= r.store_ok;
    do @(posedge clk); while (!(in_valid && !in_stall));
    cache_lookup(r, calc);
    pending_rsp.push_back(typed ? typed_rsp : calc);
    beats_sent++;
  endtask

  function automatic glyph_req_t req(logic cmd, int code, int sz, int nb, logic rok, logic sok);
    glyph_req_t r;
    r.command = cmd;
    r.key_code = 21'(code);
    r.glyph_size = 8'(sz);
    r.glyph_bytes = 16'(nb);
    r.render_ok = rok;
    r.store_ok = sok;
    return r;
  endfunction

  function automatic glyph_rsp_t rsp(logic [2:0] st, int sl, int ev, int h, int m, int c, int b);
    glyph_rsp_t o;
    o.status = st;
    o.slot = 7'(sl);
    o.evicted = 7'(ev);
    o.hits = 32'(h);
    o.misses = 32'(m);
    o.count = 7'(c);
    o.bytes = 25'(b);
    return o;
  endfunction

  function automatic script_row_t beat_row(glyph_req_t r);
    script_row_t s;
    s.is_cfg = 1'b0;
    s.reg_index = CFG_BUDGET;
    s.reg_value = '0;
    s.req = r;
    s.typed = 1'b0;
    s.rsp = rsp(ST_HIT, 0, 0, 0, 0, 0, 0);
    return s;
  endfunction

  function automatic script_row_t known_row(glyph_req_t r, glyph_rsp_t o);
    script_row_t s;
    s = beat_row(r);
    s.typed = 1'b1;
    s.rsp = o;
    return s;
  endfunction

  function automatic script_row_t reg_row(logic idx, logic [23:0] value);
    script_row_t s;
    s = beat_row(req(0, 0, 0, 0, 0, 0));
    s.is_cfg = 1'b1;
    s.reg_index = idx;
    s.reg_value = value;
    return s;
  endfunction

  // random lookup: a small key pool keeps hits and full-cache replacement
  // common, with the odd full-range key and size
  function automatic glyph_req_t random_req();
    glyph_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.command = (pick < 2);
    if ($urandom_range(0, 9) == 0) begin
      r.key_code = 21'($urandom_range(0, 1114111));
      r.glyph_size = 8'($urandom_range(0, 255));
    end else begin
      r.key_code = 21'($urandom_range(0, 199));
      r.glyph_size = 8'($urandom_range(1, 4));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) r.glyph_bytes = 16'($urandom_range(0, 3000));
    else if (pick < 9) r.glyph_bytes = 16'($urandom_range(0, 65535));
    else r.glyph_bytes = 0;
    r.render_ok = ($urandom_range(0, 9) != 0);
    r.store_ok = ($urandom_range(0, 9) != 0);
    return r;
  endfunction

  initial begin
    #500_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    script_row_t script [$];
    int budgets [7];
    glyph_rsp_t none;
    none = rsp(ST_HIT, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
    mirror_reset();

    // directed part
    script.push_back(known_row(req(0, 0, 1, 10, 1, 1), rsp(ST_REJECT, 0, 0, 0, 0, 0, 0)));
    script.push_back(reg_row(CFG_FONT, 24'd1));
    script.push_back(known_row(req(0, 0, 0, 10, 1, 1), rsp(ST_REJECT, 0, 0, 0, 0, 0, 0)));
    script.push_back(known_row(req(0, 1114111, 255, 65535, 1, 1),
                               rsp(ST_MISS, 0, 0, 0, 1, 1, 65535)));
    script.push_back(known_row(req(0, 1114111, 255, 0, 0, 0),
                               rsp(ST_HIT, 0, 0, 1, 1, 1, 65535)));
    script.push_back(known_row(req(0, 5, 1, 100, 0, 1), rsp(ST_RFAIL, 0, 0, 1, 1, 1, 65535)));
    script.push_back(beat_row(req(0, 6, 1, 0, 1, 0)));        // zero bytes, store_ok ignored
    script.push_back(beat_row(req(0, 7, 2, 65535, 1, 0)));    // store failure
    script.push_back(beat_row(req(0, 8, 3, 65535, 1, 1)));
    script.push_back(beat_row(req(0, 9, 3, 65535, 1, 1)));    // fits just under the budget, nothing evicted
    script.push_back(beat_row(req(0, 1114111, 255, 0, 1, 1)));
    script.push_back(known_row(req(1, 0, 0, 0, 0, 0), rsp(ST_CLEAR, 0, 0, 0, 0, 0, 0)));
    script.push_back(beat_row(req(0, 20, 4, 500, 1, 1)));
    script.push_back(beat_row(req(0, 21, 4, 500, 1, 1)));
    script.push_back(reg_row(CFG_BUDGET, 24'd0));             // budget below byte total
    script.push_back(beat_row(req(0, 10, 8, 100, 1, 1)));     // lone glyph above budget
    script.push_back(beat_row(req(0, 11, 8, 1, 1, 1)));
    script.push_back(beat_row(req(0, 12, 8, 0, 1, 1)));
    script.push_back(beat_row(req(0, 13, 8, 7, 1, 0)));       // evicts, then fails
    script.push_back(reg_row(CFG_BUDGET, 24'hFF_FFFF));
    script.push_back(beat_row(req(0, 0, 255, 65535, 1, 1)));
    script.push_back(reg_row(CFG_FONT, 24'd0));
    script.push_back(beat_row(req(0, 0, 255, 65535, 1, 1)));
    script.push_back(known_row(req(1, 1114111, 255, 65535, 1, 1),
                               rsp(ST_CLEAR, 0, 0, 0, 0, 0, 0)));
    script.push_back(reg_row(CFG_FONT, 24'd1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].reg_index, script[i].reg_value);
      else send_beat(script[i].req, script[i].typed, script[i].rsp);
    end

    // random part, one budget setting per phase
    budgets = '{196608, 0, 24'hFF_FFFF, 20000, 50000, 3000, 196608};
    budgets[5] = $urandom_range(0, 24'hFF_FFFF);
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_BUDGET, 24'(budgets[ph]));
      write_reg(CFG_FONT, (ph == 4) ? 24'd0 : 24'd1);
      no_gaps = (ph == 3);
      for (int n = 0; n < 62; n++) begin
        if (ph == 1 && n == 10) hold_long = 1'b1;
        if (ph == 2 && n == 30) drain_results();   // sender waits for everything
        if (ph == 4 && n == 20) write_reg(CFG_FONT, 24'd1);
        send_beat(random_req(), 1'b0, none);
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    $display("tb: %0d beats; hit %0d, stored %0d, rejected %0d, render fail %0d",
             beats_sent, status_seen[ST_HIT], status_seen[ST_MISS],
             status_seen[ST_REJECT], status_seen[ST_RFAIL]);
    $display("tb: store fail %0d, clear %0d, over seven budget settings",
             status_seen[ST_SFAIL], status_seen[ST_CLEAR]);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
